// File: src/assert_macros.svh
// assertion macros shared by the sequence index stepper rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked outside reset
`define SIS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sis assertion failed");

// same-cycle implication, checked outside reset
`define SIS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sis implication failed");

// next-cycle implication, checked outside reset
`define SIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sis next-cycle implication failed");

`endif

// File: src/sis_pkg.sv
// shared types and constants of the sequence index stepper
// no dependencies; used by the interfaces and all modules except sis_ram
package sis_pkg;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 7;
    localparam int CFG_W  = 7;
    localparam int CFG_IDX_W = 3;

    // input item function codes
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // signed working width of the move unit
    localparam int MOVE_W = POS_W + 2;
    localparam logic signed [MOVE_W-1:0] MOVE_ONE    = 1;
    localparam logic signed [MOVE_W-1:0] BOUNCE_STEP = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEQ_LENGTH    = 3'd0,
        REG_STEP_SIZE     = 3'd1,
        REG_UNDERFLOW_POS = 3'd2,
        REG_OVERFLOW_POS  = 3'd3,
        REG_BOUNCE_MODE   = 3'd4
    } sis_reg_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LATCH,
        S_MOVE,
        S_EMIT
    } sis_state_t;

    // configuration seen by the move unit
    typedef struct packed {
        logic [POS_W-1:0] seq_length;
        logic [POS_W-1:0] underflow_pos;
        logic [POS_W-1:0] overflow_pos;
        logic             bounce_mode;
    } sis_cfg_t;

    // position state in and out of the move unit
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             moving_back;
    } sis_pos_t;

endpackage

// File: src/sis_in_if.sv
// input channel of the sequence index stepper: valid, ready and item payload
// depends on sis_pkg
interface sis_in_if import sis_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;

    modport source (output valid, func, entry_index, entry_value, input ready);
    modport sink (input valid, func, entry_index, entry_value, output ready);
endinterface

// File: src/sis_out_if.sv
// output channel of the sequence index stepper: valid, ready and result payload
// depends on sis_pkg
interface sis_out_if import sis_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         read_position;
    logic                     index_fault;

    modport source (output valid, out_value, read_position, index_fault, input ready);
    modport sink (input valid, out_value, read_position, index_fault, output ready);
endinterface

// File: src/sis_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing; contents are undefined until written
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/sis_move_unit.sv
// shared move unit: one single-place move of the position with boundary handling
// depends on sis_pkg
module sis_move_unit import sis_pkg::*; (
    input  sis_cfg_t cfg,
    input  sis_pos_t cur,
    output sis_pos_t nxt
);

    logic signed [MOVE_W-1:0] pos_s;
    logic signed [MOVE_W-1:0] len_s;
    logic                     back;

    assign len_s = $signed({2'b00, cfg.seq_length});

    // step, then overflow check, then underflow check on the updated value
    always_comb
    begin
        back  = cur.moving_back;
        pos_s = cur.moving_back ? $signed({2'b00, cur.position}) - MOVE_ONE
                                : $signed({2'b00, cur.position}) + MOVE_ONE;
        if (pos_s >= len_s)
        begin
            if (!cfg.bounce_mode)
            begin
                pos_s = $signed({2'b00, cfg.overflow_pos});
            end
            else
            begin
                back  = 1'b1;
                pos_s = pos_s - BOUNCE_STEP;
            end
        end
        if (pos_s < 0)
        begin
            if (!cfg.bounce_mode)
            begin
                pos_s = $signed({2'b00, cfg.underflow_pos});
            end
            else
            begin
                back  = 1'b0;
                pos_s = pos_s + BOUNCE_STEP;
            end
        end
        nxt.position    = pos_s[POS_W-1:0];
        nxt.moving_back = back;
    end

endmodule

// File: src/sequence_index_stepper_core.sv
// top level of the sequence index stepper: config registers, sequencer, table ram
// depends on sis_pkg, sis_in_if, sis_out_if, sis_ram, sis_move_unit, assert_macros.svh
//
// A write item (func 0) stores entry_value into the table and gives no result; the
// next item can be taken at the following edge. An advance item (func 1) starts a
// registered read of the table ram at its transfer; then S_LATCH takes the read data,
// S_MOVE makes step_size passes through the single shared move unit (one place per
// cycle, boundary checked each time), and S_EMIT loads the output register. Empty
// table, single entry, a position outside the table and a zero step skip the move
// passes. The input is not ready while an advance is in progress and is ready again
// in the cycle after the output register loads. A finished result waits in the
// output register without holding up the next item, and an advance only stalls in
// S_EMIT while that register is still full.
module sequence_index_stepper_core import sis_pkg::*; #(
    parameter int SEQ_DEPTH  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    sis_in_if.sink               in_stream,
    sis_out_if.source            out_stream
);

`include "assert_macros.svh"

    localparam int ADDR_W = $clog2(SEQ_DEPTH);

    // configuration registers
    logic [POS_W-1:0] seq_length_reg;
    logic [POS_W-1:0] step_size_reg;
    logic [POS_W-1:0] underflow_pos_reg;
    logic [POS_W-1:0] overflow_pos_reg;
    logic             bounce_mode_reg;

    // sequencer state
    sis_state_t       state_reg, state_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic             moving_back_reg, moving_back_next;
    logic [POS_W-1:0] move_cnt_reg, move_cnt_next;

    // pending result
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    logic [POS_W-1:0]         res_pos_reg, res_pos_next;
    logic                     res_fault_reg, res_fault_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic [POS_W-1:0]         out_pos_reg, out_pos_next;
    logic                     out_fault_reg, out_fault_next;

    // ram and move unit hookup
    logic                  in_xfer;
    logic                  adv_xfer;
    logic                  wr_xfer;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [VALUE_BITS-1:0] ram_rd_data;
    sis_cfg_t              move_cfg;
    sis_pos_t              move_cur;
    sis_pos_t              move_nxt;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg    <= '0;
            step_size_reg     <= POS_W'(1);
            underflow_pos_reg <= '0;
            overflow_pos_reg  <= '0;
            bounce_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEQ_LENGTH:
                begin
                    if (int'(cfg_wdata) > SEQ_DEPTH)
                    begin
                        seq_length_reg <= POS_W'(SEQ_DEPTH);
                    end
                    else
                    begin
                        seq_length_reg <= cfg_wdata;
                    end
                end
                REG_STEP_SIZE:
                begin
                    if (cfg_wdata <= seq_length_reg)
                    begin
                        step_size_reg <= cfg_wdata;
                    end
                end
                REG_UNDERFLOW_POS:
                begin
                    if (cfg_wdata <= seq_length_reg)
                    begin
                        underflow_pos_reg <= cfg_wdata;
                    end
                end
                REG_OVERFLOW_POS:
                begin
                    if (cfg_wdata <= seq_length_reg)
                    begin
                        overflow_pos_reg <= cfg_wdata;
                    end
                end
                REG_BOUNCE_MODE:
                begin
                    bounce_mode_reg <= cfg_wdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // table ram
    assign in_xfer     = in_stream.valid && in_stream.ready;
    assign adv_xfer    = in_xfer && (in_stream.func == FUNC_ADVANCE);
    assign wr_xfer     = in_xfer && (in_stream.func == FUNC_WRITE);
    assign ram_wr_en   = wr_xfer && (int'(in_stream.entry_index) < SEQ_DEPTH);
    assign ram_rd_en   = adv_xfer;
    assign ram_rd_addr = (seq_length_reg == POS_W'(1)) ? '0 : ADDR_W'(position_reg);

    sis_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SEQ_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(in_stream.entry_index)),
        .wr_data (VALUE_BITS'(in_stream.entry_value)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // shared move unit
    assign move_cfg.seq_length    = seq_length_reg;
    assign move_cfg.underflow_pos = underflow_pos_reg;
    assign move_cfg.overflow_pos  = overflow_pos_reg;
    assign move_cfg.bounce_mode   = bounce_mode_reg;
    assign move_cur.position      = position_reg;
    assign move_cur.moving_back   = moving_back_reg;

    sis_move_unit u_move (
        .cfg (move_cfg),
        .cur (move_cur),
        .nxt (move_nxt)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        position_next    = position_reg;
        moving_back_next = moving_back_reg;
        move_cnt_next    = move_cnt_reg;
        res_value_next   = res_value_reg;
        res_pos_next     = res_pos_reg;
        res_fault_next   = res_fault_reg;
        out_valid_next   = out_valid_reg && !out_stream.ready;
        out_value_next   = out_value_reg;
        out_pos_next     = out_pos_reg;
        out_fault_next   = out_fault_reg;
        in_stream.ready  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_stream.ready = 1'b1;
                if (in_stream.valid && (in_stream.func == FUNC_ADVANCE))
                begin
                    state_next = S_LATCH;
                end
            end
            S_LATCH:
            begin
                move_cnt_next  = '0;
                res_value_next = '0;
                res_pos_next   = '0;
                res_fault_next = 1'b0;
                if (seq_length_reg == '0)
                begin
                    // empty table gives zero
                end
                else if (seq_length_reg == POS_W'(1))
                begin
                    res_value_next = DATA_W'(ram_rd_data);
                end
                else if (position_reg >= seq_length_reg)
                begin
                    res_pos_next   = position_reg;
                    res_fault_next = 1'b1;
                end
                else
                begin
                    res_value_next = DATA_W'(ram_rd_data);
                    res_pos_next   = position_reg;
                    move_cnt_next  = step_size_reg;
                end
                state_next = (move_cnt_next != '0) ? S_MOVE : S_EMIT;
            end
            S_MOVE:
            begin
                position_next    = move_nxt.position;
                moving_back_next = move_nxt.moving_back;
                move_cnt_next    = move_cnt_reg - POS_W'(1);
                if (move_cnt_reg == POS_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_stream.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_pos_next   = res_pos_reg;
                    out_fault_next = res_fault_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            moving_back_reg <= 1'b0;
            move_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            position_reg    <= position_next;
            moving_back_reg <= moving_back_next;
            move_cnt_reg    <= move_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_pos_reg   <= res_pos_next;
        res_fault_reg <= res_fault_next;
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
        out_fault_reg <= out_fault_next;
    end

    // output channel
    assign out_stream.valid         = out_valid_reg;
    assign out_stream.out_value     = out_value_reg;
    assign out_stream.read_position = out_pos_reg;
    assign out_stream.index_fault   = out_fault_reg;

    // checks
    `SIS_ASSERT_IMPLY(a_move_cnt_live, state_reg == S_MOVE, move_cnt_reg != '0)
    `SIS_ASSERT_NEXT(a_advance_to_latch, adv_xfer, state_reg == S_LATCH)
    `SIS_ASSERT_NEXT(a_write_stays_idle, wr_xfer, state_reg == S_IDLE)
    `SIS_ASSERT(a_fault_zero, !(out_valid_reg && out_fault_reg) || (out_value_reg == '0))

endmodule
